// ===== rtl/core/lin_frame_builder_assert.svh =====
// Assertion macros for the LIN frame builder checker.
`ifndef LIN_FRAME_BUILDER_ASSERT_SVH
`define LIN_FRAME_BUILDER_ASSERT_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define LFB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: when trig holds, expect holds in the same cycle.
`define LFB_ASSERT_IMPL(lbl, clk, rst_n, trig, expect_c, msg) \
	`LFB_ASSERT(lbl, clk, rst_n, (trig) |-> (expect_c), msg)

`endif

// ===== rtl/core/lfb_pkg.sv =====
// Shared types, constants and functions of the LIN frame builder.
package lfb_pkg;

	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned FRAME_ID_W     = 8;
	localparam int unsigned ID_W           = 6;
	localparam int unsigned CNT_W          = 4;
	localparam int unsigned MAX_DATA_BYTES = 8;

	localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h55;
	localparam logic [BYTE_W-1:0] ERR_BYTE   = 8'h00;
	localparam logic [CNT_W-1:0]  MAX_COUNT  = CNT_W'(MAX_DATA_BYTES);

	typedef logic [BYTE_W-1:0] byte_t;

	// Sequencer states: the byte that goes out next.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SYNC,
		ST_PID,
		ST_DATA,
		ST_CSUM
	} state_t;

	// Source of the byte loaded into the output register.
	typedef enum logic [2:0] {
		SEL_SYNC,
		SEL_PID,
		SEL_DATA,
		SEL_CSUM,
		SEL_ERR
	} byte_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      emit;
		byte_sel_t sel;
	} lfb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic id_bad;
		logic cnt_zero;
		logic cnt_one;
	} lfb_status_t;

	// Protected identifier: parity P0 in bit 6, inverted P1 in bit 7.
	function automatic byte_t protect_id(input logic [ID_W-1:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id};
	endfunction

	// Add one byte with end-around carry.
	function automatic byte_t carry_add(input byte_t acc, input byte_t d);
		logic [BYTE_W:0] sum;
		sum = {1'b0, acc} + {1'b0, d};
		return sum[BYTE_W-1:0] + BYTE_W'(sum[BYTE_W]);
	endfunction

endpackage

// ===== rtl/core/lfb_ctrl.sv =====
// Controller state machine of the LIN frame builder.
module lfb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  lfb_pkg::lfb_status_t status,
	output lfb_pkg::lfb_cmd_t    cmd
);

	lfb_pkg::state_t state_q;
	lfb_pkg::state_t state_d;
	logic            out_valid_q;
	logic            slot_free;

	// Output register can take a byte when empty or being drained
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == lfb_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		cmd.sel  = lfb_pkg::SEL_SYNC;
		unique case (state_q)
			lfb_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = lfb_pkg::ST_SYNC;
				end
			end
			lfb_pkg::ST_SYNC: begin
				cmd.emit = slot_free;
				if (status.id_bad) begin
					cmd.sel = lfb_pkg::SEL_ERR;
					if (slot_free) state_d = lfb_pkg::ST_IDLE;
				end else begin
					cmd.sel = lfb_pkg::SEL_SYNC;
					if (slot_free) state_d = lfb_pkg::ST_PID;
				end
			end
			lfb_pkg::ST_PID: begin
				cmd.emit = slot_free;
				cmd.sel  = lfb_pkg::SEL_PID;
				if (slot_free) begin
					state_d = status.cnt_zero ? lfb_pkg::ST_IDLE : lfb_pkg::ST_DATA;
				end
			end
			lfb_pkg::ST_DATA: begin
				cmd.emit = slot_free;
				cmd.sel  = lfb_pkg::SEL_DATA;
				if (slot_free && status.cnt_one) state_d = lfb_pkg::ST_CSUM;
			end
			lfb_pkg::ST_CSUM: begin
				cmd.emit = slot_free;
				cmd.sel  = lfb_pkg::SEL_CSUM;
				if (slot_free) state_d = lfb_pkg::ST_IDLE;
			end
			default: begin
				state_d = lfb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/lfb_dp.sv =====
// Datapath of the LIN frame builder: request capture, checksum and output register.
module lfb_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_data,
	input  logic [7:0]           frame_id,
	input  logic [3:0]           data_count,
	input  logic [7:0]           data_0,
	input  logic [7:0]           data_1,
	input  logic [7:0]           data_2,
	input  logic [7:0]           data_3,
	input  logic [7:0]           data_4,
	input  logic [7:0]           data_5,
	input  logic [7:0]           data_6,
	input  logic [7:0]           data_7,
	input  lfb_pkg::lfb_cmd_t    cmd,
	output lfb_pkg::lfb_status_t status,
	output logic [7:0]           tx_byte,
	output logic                 break_before,
	output logic                 last_byte,
	output logic                 id_error
);

	logic                          classic_q;
	logic [lfb_pkg::ID_W-1:0]      id_q;
	logic                          id_bad_q;
	logic [lfb_pkg::CNT_W-1:0]     cnt_q;
	lfb_pkg::byte_t                data_q [lfb_pkg::MAX_DATA_BYTES];
	lfb_pkg::byte_t                acc_q;
	lfb_pkg::byte_t                pid;
	lfb_pkg::byte_t                tx_byte_q;
	logic                          break_q;
	logic                          last_q;
	logic                          err_q;

	assign pid             = lfb_pkg::protect_id(id_q);
	assign status.id_bad   = id_bad_q;
	assign status.cnt_zero = (cnt_q == '0);
	assign status.cnt_one  = (cnt_q == lfb_pkg::CNT_W'(1));

	assign tx_byte      = tx_byte_q;
	assign break_before = break_q;
	assign last_byte    = last_q;
	assign id_error     = err_q;

	// Checksum mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			classic_q <= 1'b0;
		end else if (cfg_valid) begin
			classic_q <= cfg_data;
		end
	end

	// Capture the request, then shift data bytes out one at a time
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q     <= frame_id[lfb_pkg::ID_W-1:0];
			id_bad_q <= (frame_id[lfb_pkg::FRAME_ID_W-1:lfb_pkg::ID_W] != '0);
			cnt_q    <= (data_count > lfb_pkg::MAX_COUNT) ? lfb_pkg::MAX_COUNT : data_count;
			data_q[0] <= data_0;
			data_q[1] <= data_1;
			data_q[2] <= data_2;
			data_q[3] <= data_3;
			data_q[4] <= data_4;
			data_q[5] <= data_5;
			data_q[6] <= data_6;
			data_q[7] <= data_7;
		end else if (cmd.emit && cmd.sel == lfb_pkg::SEL_DATA) begin
			cnt_q <= cnt_q - lfb_pkg::CNT_W'(1);
			for (int i = 0; i < lfb_pkg::MAX_DATA_BYTES - 1; i++) begin
				data_q[i] <= data_q[i+1];
			end
		end
	end

	// Load the output register and advance the checksum
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (cmd.sel)
				lfb_pkg::SEL_SYNC: begin
					tx_byte_q <= lfb_pkg::SYNC_BYTE;
					break_q   <= 1'b1;
					last_q    <= 1'b0;
					err_q     <= 1'b0;
				end
				lfb_pkg::SEL_PID: begin
					tx_byte_q <= pid;
					break_q   <= 1'b0;
					last_q    <= status.cnt_zero;
					err_q     <= 1'b0;
					acc_q     <= classic_q ? '0 : pid;
				end
				lfb_pkg::SEL_DATA: begin
					tx_byte_q <= data_q[0];
					break_q   <= 1'b0;
					last_q    <= 1'b0;
					err_q     <= 1'b0;
					acc_q     <= lfb_pkg::carry_add(acc_q, data_q[0]);
				end
				lfb_pkg::SEL_CSUM: begin
					tx_byte_q <= ~acc_q;
					break_q   <= 1'b0;
					last_q    <= 1'b1;
					err_q     <= 1'b0;
				end
				default: begin
					tx_byte_q <= lfb_pkg::ERR_BYTE;
					break_q   <= 1'b0;
					last_q    <= 1'b1;
					err_q     <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/lin_frame_builder.sv =====
// LIN frame builder top level: sync, protected identifier, data and checksum bytes.
//
// Input channel (in_valid/in_ready): one frame request, frame_id, data_count
// and data_0..data_7. Output channel (out_valid/out_ready): one byte per
// request, with break_before on the sync byte, last_byte on the final byte
// of the frame and id_error on the single byte of a rejected identifier.
// Configuration channel (cfg_valid/cfg_ready/cfg_data): cfg_data = 1 selects
// the classic checksum (data only), 0 the enhanced checksum (PID included).
// cfg_ready is always high; write it only while no frame is in flight.
//
// On acceptance the request is captured and the sequencer moves to its
// sync state, which loads the sync byte into the output register. A frame
// then sends the PID, its data bytes and the checksum; with no data bytes
// it ends at the PID, and a rejected identifier sends only the error byte.
// The sequencer emits one byte per cycle while the receiver keeps up, into a
// single output register, and the next request is taken the cycle after the
// last byte is loaded, while that byte still waits to be taken.
// A stalled receiver holds the output register and the sequencer in place.
// Reset empties the output register, returns to idle and selects the
// enhanced checksum.
module lin_frame_builder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] frame_id,
	input  logic [3:0] data_count,
	input  logic [7:0] data_0,
	input  logic [7:0] data_1,
	input  logic [7:0] data_2,
	input  logic [7:0] data_3,
	input  logic [7:0] data_4,
	input  logic [7:0] data_5,
	input  logic [7:0] data_6,
	input  logic [7:0] data_7,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] tx_byte,
	output logic       break_before,
	output logic       last_byte,
	output logic       id_error
);

	lfb_pkg::lfb_cmd_t    cmd;
	lfb_pkg::lfb_status_t status;

	assign cfg_ready = 1'b1;

	lfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lfb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.frame_id     (frame_id),
		.data_count   (data_count),
		.data_0       (data_0),
		.data_1       (data_1),
		.data_2       (data_2),
		.data_3       (data_3),
		.data_4       (data_4),
		.data_5       (data_5),
		.data_6       (data_6),
		.data_7       (data_7),
		.cmd          (cmd),
		.status       (status),
		.tx_byte      (tx_byte),
		.break_before (break_before),
		.last_byte    (last_byte),
		.id_error     (id_error)
	);

endmodule

// ===== rtl/core/lfb_checker.sv =====
// Port-level assertion checker for the LIN frame builder, with its bind.
`include "lin_frame_builder_assert.svh"

module lfb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] tx_byte,
	input logic       break_before,
	input logic       last_byte,
	input logic       id_error
);

	// Hold a stalled byte request
	`LFB_ASSERT(a_out_hold, clk, arst_n, (out_valid && !out_ready) |=> out_valid, "out_valid dropped while stalled")
	`LFB_ASSERT(a_out_stable, clk, arst_n, (out_valid && !out_ready) |=> $stable(tx_byte), "tx_byte changed while stalled")

	// Sync byte opens a frame and never ends it
	`LFB_ASSERT_IMPL(a_sync_byte, clk, arst_n, out_valid && break_before, tx_byte == 8'h55 && !last_byte && !id_error, "bad sync byte")

	// Rejected identifier yields one closing zero byte
	`LFB_ASSERT_IMPL(a_err_byte, clk, arst_n, out_valid && id_error, tx_byte == 8'h00 && last_byte && !break_before, "bad error byte")

endmodule

bind lin_frame_builder lfb_checker u_lfb_checker (.*);
